// File: rtl/cpc_pkg.sv
package cpc_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_COS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_SIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SQUARES_X   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SQUARES_Y   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SQUARE_SIZE = 3'd6;

    // cost accumulator
    localparam int                COST_W   = 48;
    localparam logic [COST_W-1:0] COST_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [COST_W-1:0] ONE_Q16  = 48'd65536;

    // square search: quotient below 256, dividend below 2^25 when on the board
    localparam int REM_W = 25;
    localparam int QUO_W = 8;
    localparam int DIV_IDX_W = 3;

    // sequencer steps of the shared multiplier phase
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_CDX   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_SDY   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_CDY   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_SDX   = 4'd3;
    localparam logic [STEP_W-1:0] STEP_WID   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_HGT   = 4'd5;
    localparam logic [STEP_W-1:0] STEP_HLD   = 4'd6;
    localparam logic [STEP_W-1:0] STEP_SHIFT = 4'd7;
    localparam logic [STEP_W-1:0] STEP_BOUND = 4'd8;

    typedef struct packed {
        logic signed [23:0] offset_x;
        logic signed [23:0] offset_y;
        logic signed [17:0] rot_cos;
        logic signed [17:0] rot_sin;
        logic [7:0]         squares_x;
        logic [7:0]         squares_y;
        logic [15:0]        square_size;
    } cfg_t;

    typedef struct packed {
        logic                 load;
        logic                 calc_en;
        logic [STEP_W-1:0]    step;
        logic                 div_en;
        logic [DIV_IDX_W-1:0] div_idx;
        logic                 pen_en;
        logic                 acc_en;
    } cmd_t;

    typedef struct packed {
        logic in_gray;
        logic last_pending;
        logic out_busy;
    } status_t;

endpackage

// File: rtl/cpc_regs.sv
module cpc_regs
    import cpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_x    <= 24'sd0;
            cfg_reg.offset_y    <= 24'sd0;
            cfg_reg.rot_cos     <= 18'sd65536;
            cfg_reg.rot_sin     <= 18'sd0;
            cfg_reg.squares_x   <= 8'd8;
            cfg_reg.squares_y   <= 8'd7;
            cfg_reg.square_size <= 16'd6554;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_addr)
                REG_OFFSET_X:    cfg_reg.offset_x    <= $signed(cfg_data);
                REG_OFFSET_Y:    cfg_reg.offset_y    <= $signed(cfg_data);
                REG_ROT_COS:     cfg_reg.rot_cos     <= $signed(cfg_data[17:0]);
                REG_ROT_SIN:     cfg_reg.rot_sin     <= $signed(cfg_data[17:0]);
                REG_SQUARES_X:   cfg_reg.squares_x   <= cfg_data[7:0];
                REG_SQUARES_Y:   cfg_reg.squares_y   <= cfg_data[7:0];
                REG_SQUARE_SIZE: cfg_reg.square_size <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

endmodule

// File: rtl/cpc_ctrl.sv
module cpc_ctrl
    import cpc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CALC = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_PEN  = 3'd3;
    localparam logic [2:0] S_ACC  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = STEP_CDX;
                    state_next = status.in_gray ? S_ACC : S_CALC;
                end
            end
            S_CALC:
            begin
                cmd.calc_en = 1'b1;
                cmd.step    = cnt_reg;
                if (cnt_reg == STEP_BOUND)
                begin
                    cnt_next   = STEP_W'(QUO_W - 1);
                    state_next = S_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DIV:
            begin
                cmd.div_en  = 1'b1;
                cmd.div_idx = cnt_reg[DIV_IDX_W-1:0];
                if (cnt_reg == '0)
                begin
                    state_next = S_PEN;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_PEN:
            begin
                cmd.pen_en = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                // a finishing set waits for the output register to free up
                if (!(status.last_pending && status.out_busy))
                begin
                    cmd.acc_en = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: rtl/cpc_dp.sv
module cpc_dp
    import cpc_pkg::*;
#(
    parameter int COORD_WIDTH = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic [COORD_WIDTH-1:0] in_x,
    input  logic [COORD_WIDTH-1:0] in_y,
    input  logic [1:0]             in_class,
    input  logic                   in_last,
    input  cmd_t                   cmd,
    output status_t                status,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [COST_W-1:0]      out_data
);

    localparam int DXW = ((COORD_WIDTH > 24) ? COORD_WIDTH : 24) + 1;
    localparam int PW  = 18 + DXW;
    localparam int AW  = PW + 1;
    localparam int LW  = AW - 16;
    localparam int XW  = LW + 2;
    localparam int DW  = XW + 1;

    logic signed [DXW-1:0] dx_reg, dy_reg;
    logic                  last_reg, gray_reg, cls0_reg;
    logic signed [PW-1:0]  prod_reg;
    logic signed [AW-1:0]  lxacc_reg, lyacc_reg;
    logic signed [LW-1:0]  lx_reg, ly_reg;
    logic [23:0]           w_reg, h_reg;
    logic signed [XW-1:0]  x2_reg, y2_reg;
    logic                  onx_reg, ony_reg;
    logic [XW-1:0]         ox_reg, oy_reg;
    logic [REM_W-1:0]      remx_reg, remy_reg;
    logic [QUO_W-1:0]      qx_reg, qy_reg;
    logic [DW-1:0]         d2_reg;
    logic [COST_W-1:0]     add_reg;
    logic [COST_W-1:0]     cost_reg;
    logic [COST_W-1:0]     out_data_reg;
    logic                  out_valid_reg;

    logic signed [17:0]    mul_a;
    logic signed [DXW-1:0] mul_b;
    logic signed [PW-1:0]  mul_p;
    logic signed [AW-1:0]  lx_rnd, ly_rnd;
    logic signed [XW-1:0]  lim2w, lim2h, negdiv;
    logic [REM_W-1:0]      div_sh;
    logic                  on_board, mism;
    logic [COST_W-1:0]     d2_ext, pen_val, add_eff;
    logic [COST_W:0]       sum_w;
    logic [COST_W-1:0]     sum_sat;

    assign status.in_gray      = in_class[1];
    assign status.last_pending = last_reg;
    assign status.out_busy     = out_valid_reg & ~out_ready;
    assign out_valid           = out_valid_reg;
    assign out_data            = out_data_reg;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.step)
            STEP_CDX:
            begin
                mul_a = cfg.rot_cos;
                mul_b = dx_reg;
            end
            STEP_SDY:
            begin
                mul_a = cfg.rot_sin;
                mul_b = dy_reg;
            end
            STEP_CDY:
            begin
                mul_a = cfg.rot_cos;
                mul_b = dy_reg;
            end
            STEP_SDX:
            begin
                mul_a = cfg.rot_sin;
                mul_b = dx_reg;
            end
            STEP_WID:
            begin
                mul_a = $signed({10'd0, cfg.squares_x});
                mul_b = $signed(DXW'(cfg.square_size));
            end
            STEP_HGT:
            begin
                mul_a = $signed({10'd0, cfg.squares_y});
                mul_b = $signed(DXW'(cfg.square_size));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // round half up, then drop the fraction bits of the rotation
    assign lx_rnd = lxacc_reg + $signed(AW'(32768));
    assign ly_rnd = lyacc_reg + $signed(AW'(32768));

    assign lim2w  = $signed(XW'({w_reg, 1'b0}));
    assign lim2h  = $signed(XW'({h_reg, 1'b0}));
    assign negdiv = -$signed(XW'({cfg.square_size, 1'b0}));
    assign div_sh = REM_W'({cfg.square_size, 1'b0}) << cmd.div_idx;

    assign on_board = onx_reg & ony_reg & (cfg.square_size != '0);
    // square is white on an even col+row
    assign mism     = ~(qx_reg[0] ^ qy_reg[0]) ^ cls0_reg;
    assign d2_ext   = COST_W'(d2_reg);
    assign pen_val  = (d2_ext << 5) + (d2_ext << 4) + (d2_ext << 1);

    assign add_eff = gray_reg ? '0 : add_reg;
    assign sum_w   = {1'b0, cost_reg} + {1'b0, add_eff};
    assign sum_sat = sum_w[COST_W] ? COST_MAX : sum_w[COST_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dx_reg   <= DXW'($signed(in_x)) - DXW'(cfg.offset_x);
            dy_reg   <= DXW'($signed(in_y)) - DXW'(cfg.offset_y);
            last_reg <= in_last;
            gray_reg <= in_class[1];
            cls0_reg <= in_class[0];
        end

        if (cmd.calc_en)
        begin
            prod_reg <= mul_p;
            case (cmd.step)
                STEP_SDY:   lxacc_reg <= AW'(prod_reg);
                STEP_CDY:   lxacc_reg <= lxacc_reg + AW'(prod_reg);
                STEP_SDX:   lyacc_reg <= AW'(prod_reg);
                STEP_WID:   lyacc_reg <= lyacc_reg - AW'(prod_reg);
                STEP_HGT:
                begin
                    w_reg  <= prod_reg[23:0];
                    lx_reg <= lx_rnd[AW-1:16];
                end
                STEP_HLD:
                begin
                    h_reg  <= prod_reg[23:0];
                    ly_reg <= ly_rnd[AW-1:16];
                end
                STEP_SHIFT:
                begin
                    x2_reg <= (XW'(lx_reg) <<< 1) + $signed(XW'(w_reg));
                    y2_reg <= (XW'(ly_reg) <<< 1) + $signed(XW'(h_reg));
                end
                STEP_BOUND:
                begin
                    onx_reg  <= (cfg.squares_x != '0) && (x2_reg > negdiv) && (x2_reg < lim2w);
                    ony_reg  <= (cfg.squares_y != '0) && (y2_reg > negdiv) && (y2_reg < lim2h);
                    ox_reg   <= (x2_reg < 0) ? XW'(-x2_reg)
                              : ((x2_reg > lim2w) ? XW'(x2_reg - lim2w) : '0);
                    oy_reg   <= (y2_reg < 0) ? XW'(-y2_reg)
                              : ((y2_reg > lim2h) ? XW'(y2_reg - lim2h) : '0);
                    remx_reg <= (x2_reg < 0) ? '0 : x2_reg[REM_W-1:0];
                    remy_reg <= (y2_reg < 0) ? '0 : y2_reg[REM_W-1:0];
                    qx_reg   <= '0;
                    qy_reg   <= '0;
                end
                default: ;
            endcase
        end

        // restoring division, one quotient bit per beat in each lane
        if (cmd.div_en)
        begin
            if (remx_reg >= div_sh)
            begin
                remx_reg                <= remx_reg - div_sh;
                qx_reg[cmd.div_idx]     <= 1'b1;
            end
            if (remy_reg >= div_sh)
            begin
                remy_reg                <= remy_reg - div_sh;
                qy_reg[cmd.div_idx]     <= 1'b1;
            end
            d2_reg <= DW'(ox_reg) + DW'(oy_reg);
        end

        if (cmd.pen_en)
        begin
            add_reg <= on_board ? (mism ? ONE_Q16 : '0) : pen_val;
        end

        if (cmd.acc_en && last_reg)
        begin
            out_data_reg <= sum_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cost_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.acc_en)
            begin
                cost_reg <= last_reg ? '0 : sum_sat;
            end
            if (cmd.acc_en && last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/checkerboard_pose_cost_top.sv
// channel   | dir | beat fields
// ----------+-----+------------------------------------------------------------
// s_axis    | in  | tdata: point_x, point_y (lowest first); tuser: color_class;
//           |     | tlast: last
// m_axis    | out | tdata: total_cost (48 bit, Q32.16, saturating)
// cfg       | in  | cfg_addr: register index, cfg_data: value (low bits used)
//
// a black or white point passes from accept to the next accept through the accept
// step, nine steps through the single shared 18 x (max(coord,24)+1) multiplier
// with its rounding and bound checks, eight steps of the bit-per-cycle square
// divider, a penalty step and an accumulate step; a gray point skips to accumulate
// reset clears the running cost and loads the default board registers
// a last point waits in the accumulate step while the output beat is unread;
// otherwise the input side is free again as soon as the point is folded in
module checkerboard_pose_cost_top
    import cpc_pkg::*;
#(
    parameter int COORD_WIDTH = 24
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    // stream in
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata, // point_x, point_y, zero pad
    input  logic [1:0]              s_axis_tuser,   // color_class
    input  logic                    s_axis_tlast,   // last

    // stream out
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [COST_W-1:0]       m_axis_tdata,   // total_cost

    // register writes
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_addr,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    // board geometry and pose registers
    cpc_regs u_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer: accept, multiply steps, divide steps, penalty, accumulate
    cpc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // rotation, square search, penalty and the saturating cost sum
    cpc_dp #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_x      (s_axis_tdata[COORD_WIDTH-1:0]),
        .in_y      (s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .in_class  (s_axis_tuser),
        .in_last   (s_axis_tlast),
        .cmd       (cmd),
        .status    (status),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata)
    );

    // the sequencer leaves its accept state right after taking a beat
    a_one_point_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a point is in flight");

    // a result beat only appears from the accumulate step
    a_result_from_acc: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(cmd.acc_en))
        else $error("result beat raised outside the accumulate step");

    // datapath phases never overlap
    a_phase_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.calc_en, cmd.div_en, cmd.pen_en, cmd.acc_en}))
        else $error("overlapping datapath commands");

endmodule
